### rtl/core/lavm_pkg.sv
`default_nettype none
package lavm_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DW = CW + 2;
  localparam int MW = CW + 1;
  localparam int NW = FB + 2;
  localparam int AW = NW + CW + 2;
  localparam logic [CW-1:0] ONE_FX = CW'(1) << FB;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } norm_st_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_NZ,
    B_NU,
    B_CR1,
    B_NX,
    B_CR2,
    B_NY,
    B_DOT,
    B_EMIT
  } back_st_e;

  typedef struct packed {
    logic [2:0][CW-1:0] eye;
    logic [2:0][DW-1:0] diff;
    logic [2:0][CW-1:0] up;
  } item_t;

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
  } norm_in_t;

endpackage
`default_nettype wire

### rtl/core/lavm_front.sv
`default_nettype none
module lavm_front import lavm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [2:0][CW-1:0] eye_i,
  input  wire logic [2:0][CW-1:0] target_i,
  input  wire logic [2:0][CW-1:0] up_i,
  input  wire logic          deq_i,
  output logic               valid_o,
  output item_t              item_o
);

  item_t      q_q [2];
  item_t      item_in;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       enq, deq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_in.eye[i]  = eye_i[i];
      item_in.up[i]   = up_i[i];
      item_in.diff[i] = {{2{eye_i[i][CW-1]}}, eye_i[i]}
                      - {{2{target_i[i][CW-1]}}, target_i[i]};
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign enq     = push_i && !full_o;
  assign deq     = deq_i && valid_o;
  assign item_o  = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (enq) q_q[wr_q] <= item_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) wr_q <= !wr_q;
      if (deq) rd_q <= !rd_q;
      case ({enq, deq})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/lavm_norm.sv
`default_nettype none
module lavm_norm import lavm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire norm_in_t      vec_i,
  output logic               done_o,
  output logic [2:0][NW-1:0] res_o
);

  norm_st_e st_q, st_d;

  logic [2:0]         neg_q;
  logic [2:0][MW-1:0] mag_q;
  logic               shifted_q;
  logic [63:0]        sum_q, x_q, r_q, bit_q;
  logic [5:0]         cnt_q;
  logic [1:0]         idx_q;
  logic [MW-1:0]      div_q, rem_q;
  logic [CW+FB-2:0]   num_q;
  logic [FB:0]        quo_q;
  logic [2:0][NW-1:0] res_q;

  logic               top_set;
  logic [CW-2:0]      msel;
  logic [2*CW-3:0]    sq;
  logic [63:0]        sum_nx, sq_t, r_nx, x_nx;
  logic [MW:0]        trial;
  logic               qb;
  logic [FB:0]        qfin;
  logic [NW-1:0]      qext;

  always_comb begin
    top_set = 1'b0;
    for (int i = 0; i < 3; i++) top_set = top_set | (mag_q[i][MW-1:CW-1] != 2'b00);
  end

  always_comb begin
    msel   = mag_q[idx_q][CW-2:0];
    sq     = msel * msel;
    sum_nx = sum_q + 64'(sq);
    sq_t   = r_q + bit_q;
    if (x_q >= sq_t) begin
      x_nx = x_q - sq_t;
      r_nx = (r_q >> 1) + bit_q;
    end else begin
      x_nx = x_q;
      r_nx = r_q >> 1;
    end
    trial = {rem_q, num_q[CW+FB-2]};
    qb    = trial >= {1'b0, div_q};
    qfin  = {quo_q[FB-1:0], qb};
    qext  = {1'b0, qfin};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      N_IDLE:  if (start_i) st_d = N_SHIFT;
      N_SHIFT: if (!top_set) st_d = N_SQ;
      N_SQ:    if (idx_q == 2'd2) st_d = N_SQRT;
      N_SQRT:  if (cnt_q == 6'd31) st_d = N_DIV;
      N_DIV:   if (cnt_q == 6'(CW + FB - 2) && idx_q == 2'd2) st_d = N_DONE;
      N_DONE:  st_d = N_IDLE;
      default: st_d = N_IDLE;
    endcase
  end

  always_comb begin
    done_o = st_q == N_DONE;
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= N_IDLE;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          neg_q     <= vec_i.neg;
          mag_q     <= vec_i.mag;
          shifted_q <= 1'b0;
        end
      end
      N_SHIFT: begin
        if (top_set) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          shifted_q <= 1'b1;
        end else begin
          idx_q <= 2'd0;
          sum_q <= 64'd0;
        end
      end
      N_SQ: begin
        sum_q <= sum_nx;
        if (idx_q == 2'd2) begin
          x_q   <= sum_nx;
          r_q   <= 64'd0;
          bit_q <= 64'd1 << 62;
          cnt_q <= 6'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      N_SQRT: begin
        x_q   <= x_nx;
        r_q   <= r_nx;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          div_q <= shifted_q ? {1'b0, r_nx[CW-1:0]} : {1'b0, r_nx[CW-1:0]} + MW'(1);
          idx_q <= 2'd0;
          cnt_q <= 6'd0;
          num_q <= {mag_q[0][CW-2:0], FB'(0)};
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      N_DIV: begin
        rem_q <= qb ? MW'(trial - {1'b0, div_q}) : trial[MW-1:0];
        num_q <= num_q << 1;
        quo_q <= qfin;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(CW + FB - 2)) begin
          res_q[idx_q] <= neg_q[idx_q] ? -qext : qext;
          if (idx_q != 2'd2) begin
            idx_q <= idx_q + 2'd1;
            cnt_q <= 6'd0;
            num_q <= {mag_q[idx_q + 2'd1][CW-2:0], FB'(0)};
            rem_q <= '0;
            quo_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/lavm_back.sv
`default_nettype none
module lavm_back import lavm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire item_t         item_i,
  output logic               item_deq_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [1:0]         group_index_o,
  output logic [3:0][CW-1:0] entry_o,
  output logic               final_group_o
);

  back_st_e st_q, st_d;

  item_t              it_q;
  logic               go_q;
  logic [2:0][NW-1:0] ax_q, ay_q, az_q;
  logic [2:0]         tneg_q;
  logic [2:0][NW-1:0] tmag_q;
  logic [2*NW-1:0]    prod_q;
  logic [2:0]         cnt_q;
  logic [1:0]         dv_q, dc_q;
  logic [AW-1:0]      acc_q;
  logic [2:0][CW-1:0] tr_q;

  logic               ov_q;
  logic [1:0]         grp_q;
  logic [2:0][NW-1:0] oax_q, oay_q, oaz_q;
  logic [2:0][CW-1:0] otr_q;

  norm_in_t           nin;
  logic               nstart, ndone, in_norm;
  logic [2:0][NW-1:0] nres;

  logic [1:0]             ci, cj, ck;
  logic [2:0][NW-1:0]     a_vec, b_vec;
  logic signed [NW-1:0]   mula, mulb;
  logic signed [2*NW-1:0] cmul;
  logic [2*NW:0]          cdiff, cabs;

  logic signed [NW-1:0]    da;
  logic signed [CW-1:0]    de;
  logic signed [NW+CW-1:0] dprod;
  logic [AW-1:0]           acc_nx;
  logic [AW-FB-1:0]        dsh;
  logic [CW-1:0]           dsat;

  lavm_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(nstart),
    .vec_i  (nin),
    .done_o (ndone),
    .res_o  (nres)
  );

  always_comb begin
    nin = '0;
    for (int i = 0; i < 3; i++) begin
      case (st_q)
        B_NZ: begin
          nin.neg[i] = it_q.diff[i][DW-1];
          nin.mag[i] = nin.neg[i] ? MW'(-it_q.diff[i]) : it_q.diff[i][MW-1:0];
        end
        B_NU: begin
          nin.neg[i] = it_q.up[i][CW-1];
          nin.mag[i] = nin.neg[i] ? -{it_q.up[i][CW-1], it_q.up[i]}
                                  : {it_q.up[i][CW-1], it_q.up[i]};
        end
        B_NX, B_NY: begin
          nin.neg[i] = tneg_q[i];
          nin.mag[i] = MW'(tmag_q[i]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ci = cnt_q[2:1];
    case (ci)
      2'd0:    begin cj = 2'd1; ck = 2'd2; end
      2'd1:    begin cj = 2'd2; ck = 2'd0; end
      default: begin cj = 2'd0; ck = 2'd1; end
    endcase
    if (st_q == B_CR2) begin
      a_vec = az_q;
      b_vec = ax_q;
    end else begin
      a_vec = ay_q;
      b_vec = az_q;
    end
    mula  = cnt_q[0] ? a_vec[ck] : a_vec[cj];
    mulb  = cnt_q[0] ? b_vec[cj] : b_vec[ck];
    cmul  = mula * mulb;
    cdiff = {prod_q[2*NW-1], prod_q} - {cmul[2*NW-1], cmul};
    cabs  = cdiff[2*NW] ? (~cdiff + 1'b1) : cdiff;
  end

  always_comb begin
    case (dv_q)
      2'd0:    da = ax_q[dc_q];
      2'd1:    da = ay_q[dc_q];
      default: da = az_q[dc_q];
    endcase
    de     = it_q.eye[dc_q];
    dprod  = da * de;
    acc_nx = acc_q - {{(AW-NW-CW){dprod[NW+CW-1]}}, dprod};
    dsh    = acc_nx[AW-1:FB];
    if (dsh[AW-FB-1:CW-1] == '0 || dsh[AW-FB-1:CW-1] == '1) dsat = dsh[CW-1:0];
    else if (dsh[AW-FB-1]) dsat = {1'b1, {(CW-1){1'b0}}};
    else dsat = {1'b0, {(CW-1){1'b1}}};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE:  if (item_valid_i) st_d = B_NZ;
      B_NZ:    if (ndone) st_d = B_NU;
      B_NU:    if (ndone) st_d = B_CR1;
      B_CR1:   if (cnt_q == 3'd5) st_d = B_NX;
      B_NX:    if (ndone) st_d = B_CR2;
      B_CR2:   if (cnt_q == 3'd5) st_d = B_NY;
      B_NY:    if (ndone) st_d = B_DOT;
      B_DOT:   if (dv_q == 2'd2 && dc_q == 2'd2) st_d = B_EMIT;
      B_EMIT:  if (!ov_q) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    in_norm    = st_q == B_NZ || st_q == B_NU || st_q == B_NX || st_q == B_NY;
    nstart     = in_norm && !go_q;
    item_deq_o = st_q == B_IDLE && item_valid_i;
  end

  always_comb begin
    empty_o       = !ov_q;
    group_index_o = grp_q;
    final_group_o = grp_q == 2'd3;
    case (grp_q)
      2'd3: entry_o = {ONE_FX, otr_q[2], otr_q[1], otr_q[0]};
      default: entry_o = {CW'(0),
                          {{(CW-NW){oaz_q[grp_q][NW-1]}}, oaz_q[grp_q]},
                          {{(CW-NW){oay_q[grp_q][NW-1]}}, oay_q[grp_q]},
                          {{(CW-NW){oax_q[grp_q][NW-1]}}, oax_q[grp_q]}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      go_q  <= 1'b0;
      ov_q  <= 1'b0;
      grp_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (nstart) go_q <= 1'b1;
      else if (ndone) go_q <= 1'b0;
      if (st_q == B_EMIT && !ov_q) begin
        ov_q  <= 1'b1;
        grp_q <= 2'd0;
      end else if (ov_q && pop_i) begin
        if (grp_q == 2'd3) ov_q <= 1'b0;
        else grp_q <= grp_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE: if (item_valid_i) it_q <= item_i;
      B_NZ:   if (ndone) az_q <= nres;
      B_NU: begin
        if (ndone) begin
          ay_q  <= nres;
          cnt_q <= 3'd0;
        end
      end
      B_NX: begin
        if (ndone) begin
          ax_q  <= nres;
          cnt_q <= 3'd0;
        end
      end
      B_NY: begin
        if (ndone) begin
          ay_q  <= nres;
          dv_q  <= 2'd0;
          dc_q  <= 2'd0;
          acc_q <= '0;
        end
      end
      B_CR1, B_CR2: begin
        cnt_q <= cnt_q + 3'd1;
        if (!cnt_q[0]) prod_q <= cmul;
        else begin
          tneg_q[ci] <= cdiff[2*NW];
          tmag_q[ci] <= cabs[NW+FB-1:FB];
        end
      end
      B_DOT: begin
        if (dc_q == 2'd2) begin
          tr_q[dv_q] <= dsat;
          acc_q      <= '0;
          dc_q       <= 2'd0;
          dv_q       <= dv_q + 2'd1;
        end else begin
          acc_q <= acc_nx;
          dc_q  <= dc_q + 2'd1;
        end
      end
      B_EMIT: begin
        if (!ov_q) begin
          oax_q <= ax_q;
          oay_q <= ay_q;
          oaz_q <= az_q;
          otr_q <= tr_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/look_at_view_matrix.sv
// Look-at view matrix in signed Q16.16. Each transaction on the input queue carries eye,
// target and up points; it yields four result transactions of four matrix entries each,
// in group order, the last flagged by final_group_o. Two items can wait in the input queue
// and one finished matrix waits in the output buffer while the next one is computed. Each
// item passes four times through the single shared normalize unit, which runs
// a 32-step square root and three 47-step bit-serial divides each time.
`default_nettype none
module look_at_view_matrix import lavm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [CW-1:0] eye_x_i,
  input  wire logic [CW-1:0] eye_y_i,
  input  wire logic [CW-1:0] eye_z_i,
  input  wire logic [CW-1:0] target_x_i,
  input  wire logic [CW-1:0] target_y_i,
  input  wire logic [CW-1:0] target_z_i,
  input  wire logic [CW-1:0] up_x_i,
  input  wire logic [CW-1:0] up_y_i,
  input  wire logic [CW-1:0] up_z_i,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         group_index_o,
  output logic [CW-1:0]      entry_0_o,
  output logic [CW-1:0]      entry_1_o,
  output logic [CW-1:0]      entry_2_o,
  output logic [CW-1:0]      entry_3_o,
  output logic               final_group_o
);

  item_t              item;
  logic               item_valid, item_deq;
  logic [3:0][CW-1:0] entry;

  lavm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .eye_i   ({eye_z_i, eye_y_i, eye_x_i}),
    .target_i({target_z_i, target_y_i, target_x_i}),
    .up_i    ({up_z_i, up_y_i, up_x_i}),
    .deq_i   (item_deq),
    .valid_o (item_valid),
    .item_o  (item)
  );

  lavm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_deq_o   (item_deq),
    .pop_i        (pop),
    .empty_o      (empty),
    .group_index_o(group_index_o),
    .entry_o      (entry),
    .final_group_o(final_group_o)
  );

  assign entry_0_o = entry[0];
  assign entry_1_o = entry[1];
  assign entry_2_o = entry[2];
  assign entry_3_o = entry[3];

endmodule
`default_nettype wire

### rtl/core/lavm_checker.sv
`default_nettype none
module lavm_checker import lavm_pkg::*; (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          pop,
  input wire logic          empty,
  input wire logic [1:0]    group_index_o,
  input wire logic [CW-1:0] entry_3_o,
  input wire logic          final_group_o
);

  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> final_group_o == (group_index_o == 2'd3))
    else $error("final flag does not match group");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && group_index_o != 2'd3) |=>
      (!empty && group_index_o == $past(group_index_o) + 2'd1))
    else $error("group did not advance after pop");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && group_index_o != 2'd3) |-> entry_3_o == '0)
    else $error("padding entry not zero");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && group_index_o == 2'd3) |-> entry_3_o == ONE_FX)
    else $error("last entry not one");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);
`default_nettype wire
